[rtl/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types and constants of the Gegenbauer polynomial evaluator.
// ----------------------------------------------------------------------------
package gpe_pkg;

   localparam int TERM_W    = 32;
   localparam int A_OP_W    = 42;
   localparam int CHUNK_W   = 17;
   localparam int ACC_W     = 64;
   localparam int NUM_CELLS = 2;
   localparam int RECIP_W   = 25;
   localparam int RECIP_N   = 256;

   // configuration register indexes
   localparam logic [1:0] REG_ALPHA  = 2'd0;
   localparam logic [1:0] REG_DEGREE = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_X_HI, ST_X_LO, ST_C1,
      ST_XX_HI, ST_XX_LO, ST_X2,
      ST_T_HI, ST_T_LO, ST_TS,
      ST_C2_HI, ST_C2_LO, ST_C2,
      ST_D0, ST_D1, ST_D2, ST_D3, ST_DS,
      ST_R_HI, ST_R_LO, ST_TERM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic en;
      logic clear;
      logic shift;
      logic negate;
   } mac_ctrl_type;

   typedef logic [RECIP_W-1:0] recip_table_type [RECIP_N];

   // round(2^24 / k) by shift-subtract long division
   function automatic recip_table_type build_recip();
      recip_table_type tab;
      logic [RECIP_W-1:0] num;
      logic [RECIP_W-1:0] quo;
      logic [RECIP_W:0]   rem;
      for (int k = 0; k < RECIP_N; k++) begin
         num = RECIP_W'((32'd1 << 24) + (32'(k) >> 1));
         quo = '0;
         rem = '0;
         for (int i = RECIP_W - 1; i >= 0; i--) begin
            rem = {rem[RECIP_W-1:0], num[i]};
            if (k != 0 && rem >= (RECIP_W+1)'(k)) begin
               rem = rem - (RECIP_W+1)'(k);
               quo[i] = 1'b1;
            end
         end
         tab[k] = quo;
      end
      return tab;
   endfunction

   localparam recip_table_type RECIP_ROM = build_recip();

endpackage

[rtl/gpe_cell.sv]
// ----------------------------------------------------------------------------
// gpe_cell
// One term cell of the recurrence chain: holds a term and passes it on.
// ----------------------------------------------------------------------------
module gpe_cell
   import gpe_pkg::*;
(
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic signed [TERM_W-1:0] data_in,
   output logic signed [TERM_W-1:0] data_out
);

   logic signed [TERM_W-1:0] term_ff;
   logic signed [TERM_W-1:0] term_in;

   assign term_in  = shift_en ? data_in : term_ff;
   assign data_out = term_ff;

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

endmodule

[rtl/gpe_mac.sv]
// ----------------------------------------------------------------------------
// gpe_mac
// Shared multiply-accumulate: operand times a 17-bit chunk, shift and add or subtract.
// ----------------------------------------------------------------------------
module gpe_mac
   import gpe_pkg::*;
(
   input  logic                      clock,
   input  mac_ctrl_type              ctrl,
   input  logic signed [A_OP_W-1:0]  a_op,
   input  logic signed [CHUNK_W-1:0] b_chunk,
   output logic signed [ACC_W-1:0]   acc
);

   logic signed [A_OP_W+CHUNK_W-1:0] prod;
   logic signed [ACC_W-1:0]          prod_ext;
   logic signed [ACC_W-1:0]          base;
   logic signed [ACC_W-1:0]          acc_ff;
   logic signed [ACC_W-1:0]          acc_in;

   assign prod     = a_op * b_chunk;
   assign prod_ext = ACC_W'(prod);

   always_comb begin
      if (ctrl.clear) begin
         base = '0;
      end else if (ctrl.shift) begin
         base = acc_ff <<< 16;
      end else begin
         base = acc_ff;
      end
      if (!ctrl.en) begin
         acc_in = acc_ff;
      end else if (ctrl.negate) begin
         acc_in = base - prod_ext;
      end else begin
         acc_in = base + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[rtl/gegenbauer_polynomial_eval.sv]
// one sample is in work at a time: a new beat is accepted only in idle, after the result
// of the last one has gone to the output register, which waits while a result is stalled
// every product goes through the shared 42x17 mac; a recurrence step uses it for two
// chunked products for d, one for 1/k
// reset: synchronous, clears control, alpha to 1.0 and degree to 0
// ----------------------------------------------------------------------------
// gegenbauer_polynomial_eval
// Evaluates C_n^a(x) by the upward three-term recurrence on a shared mac.
// ----------------------------------------------------------------------------
module gegenbauer_polynomial_eval
   import gpe_pkg::*;
#(
   parameter int MAX_DEGREE = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [17:0] req_sample_x,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_poly_value,
   output logic               rsp_saturated
);

   localparam int DEG_W = $clog2(MAX_DEGREE + 1);

   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                   input int s);
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(64'sd1 <<< (s - 1));
      return (v + half) >>> s;
   endfunction

   state_type state_ff, state_in;

   logic signed [15:0]   alpha_ff, alpha_in;
   logic [6:0]           degree_ff, degree_in;
   logic signed [17:0]   x_ff, x_in;
   logic [DEG_W-1:0]     n_ff, n_in, n_req;
   logic [DEG_W-1:0]     k_ff, k_in;
   logic signed [39:0]   u_ff, u_in;
   logic signed [30:0]   p_ff, p_in;
   logic signed [25:0]   q_ff, q_in;
   logic signed [21:0]   x2_ff, x2_in;
   logic signed [35:0]   t_ff, t_in;
   logic signed [40:0]   d_ff, d_in;
   logic                 sat_ff, sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                      accept;
   logic                      out_load;
   mac_ctrl_type              mac_ctrl;
   logic signed [A_OP_W-1:0]  a_op;
   logic signed [31:0]        b_full;
   logic                      b_low;
   logic signed [CHUNK_W-1:0] b_chunk;
   logic signed [ACC_W-1:0]   acc;
   logic                      cell_shift;
   logic signed [ACC_W-1:0]   term_wide;
   logic signed [TERM_W-1:0]  term_in;
   logic                      term_ovf;
   logic signed [ACC_W-1:0]   d_wide;
   logic signed [TERM_W-1:0]  cell_q [NUM_CELLS];
   logic signed [17:0]        a_plus_one;

   assign accept   = req_valid && !req_stall;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_poly_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

   always_comb begin
      if (32'(degree_ff) > 32'(MAX_DEGREE)) begin
         n_req = DEG_W'(MAX_DEGREE);
      end else begin
         n_req = DEG_W'(degree_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = (n_req == '0) ? ST_DONE : ST_X_HI;
         ST_X_HI:  state_in = ST_X_LO;
         ST_X_LO:  state_in = ST_C1;
         ST_C1:    state_in = (n_ff == DEG_W'(1)) ? ST_DONE : ST_XX_HI;
         ST_XX_HI: state_in = ST_XX_LO;
         ST_XX_LO: state_in = ST_X2;
         ST_X2:    state_in = ST_T_HI;
         ST_T_HI:  state_in = ST_T_LO;
         ST_T_LO:  state_in = ST_TS;
         ST_TS:    state_in = ST_C2_HI;
         ST_C2_HI: state_in = ST_C2_LO;
         ST_C2_LO: state_in = ST_C2;
         ST_C2:    state_in = (n_ff == DEG_W'(2)) ? ST_DONE : ST_D0;
         ST_D0:    state_in = ST_D1;
         ST_D1:    state_in = ST_D2;
         ST_D2:    state_in = ST_D3;
         ST_D3:    state_in = ST_DS;
         ST_DS:    state_in = ST_R_HI;
         ST_R_HI:  state_in = ST_R_LO;
         ST_R_LO:  state_in = ST_TERM;
         ST_TERM:  state_in = (k_ff == n_ff) ? ST_DONE : ST_D0;
         ST_DONE:  if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign a_plus_one = 18'(alpha_ff) + 18'sd4096;

   // mac operand and control per state
   always_comb begin
      mac_ctrl   = '0;
      a_op       = '0;
      b_full     = '0;
      b_low      = 1'b0;
      cell_shift = 1'b0;
      term_wide  = '0;
      case (state_ff)
         ST_X_HI, ST_X_LO: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_X_HI);
            mac_ctrl.shift = (state_ff == ST_X_LO);
            b_low          = (state_ff == ST_X_LO);
            a_op           = A_OP_W'(x_ff);
            b_full         = 32'(alpha_ff);
         end
         ST_XX_HI, ST_XX_LO: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_XX_HI);
            mac_ctrl.shift = (state_ff == ST_XX_LO);
            b_low          = (state_ff == ST_XX_LO);
            a_op           = A_OP_W'(x_ff);
            b_full         = 32'(x_ff);
         end
         ST_T_HI, ST_T_LO: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_T_HI);
            mac_ctrl.shift = (state_ff == ST_T_LO);
            b_low          = (state_ff == ST_T_LO);
            a_op           = A_OP_W'(alpha_ff);
            b_full         = 32'(a_plus_one);
         end
         ST_C2_HI, ST_C2_LO: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_C2_HI);
            mac_ctrl.shift = (state_ff == ST_C2_LO);
            b_low          = (state_ff == ST_C2_LO);
            a_op           = A_OP_W'(t_ff);
            b_full         = 32'(x2_ff);
         end
         // d = p*c_{k-1} - q*c_{k-2}, high halves first
         ST_D0, ST_D2: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_D0);
            mac_ctrl.shift = (state_ff == ST_D2);
            b_low          = (state_ff == ST_D2);
            a_op           = A_OP_W'(p_ff);
            b_full         = cell_q[0];
         end
         ST_D1, ST_D3: begin
            mac_ctrl.en     = 1'b1;
            mac_ctrl.negate = 1'b1;
            b_low           = (state_ff == ST_D3);
            a_op            = A_OP_W'(q_ff);
            b_full          = cell_q[1];
         end
         ST_R_HI, ST_R_LO: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (state_ff == ST_R_HI);
            mac_ctrl.shift = (state_ff == ST_R_LO);
            b_low          = (state_ff == ST_R_LO);
            a_op           = A_OP_W'(d_ff);
            b_full         = 32'(RECIP_ROM[8'(k_ff)]);
         end
         ST_C1: begin
            cell_shift = 1'b1;
            term_wide  = rnd(acc, 9);
         end
         ST_C2: begin
            cell_shift = 1'b1;
            term_wide  = rnd(acc - (ACC_W'(alpha_ff) <<< 26), 22);
         end
         ST_TERM: begin
            cell_shift = 1'b1;
            term_wide  = rnd(acc, 24);
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   assign b_chunk = b_low ? $signed({1'b0, b_full[15:0]}) : $signed({b_full[31], b_full[31:16]});

   always_comb begin
      term_ovf = 1'b0;
      term_in  = TERM_W'(term_wide);
      if (term_wide > 64'sh0000_0000_7FFF_FFFF) begin
         term_ovf = 1'b1;
         term_in  = 32'sh7FFF_FFFF;
      end else if (term_wide < -64'sh0000_0000_8000_0000) begin
         term_ovf = 1'b1;
         term_in  = -32'sh8000_0000;
      end
   end

   assign d_wide = rnd(acc, 16);

   // datapath register next values
   always_comb begin
      alpha_in     = alpha_ff;
      degree_in    = degree_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      sat_in       = sat_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en && csr_index == REG_ALPHA) begin
         alpha_in = $signed(csr_data);
      end
      if (csr_wr_en && csr_index == REG_DEGREE) begin
         degree_in = csr_data[6:0];
      end

      if (accept) begin
         x_in   = req_sample_x;
         n_in   = n_req;
         sat_in = 1'b0;
      end

      if (cell_shift && term_ovf) begin
         sat_in = 1'b1;
      end

      case (state_ff)
         ST_C1: begin
            u_in = 40'(acc <<< 1) + (40'(x_ff) <<< 14);
            p_in = 31'(rnd(64'(u_in), 10));
            q_in = 26'(32'sd65536 + (32'(alpha_ff) <<< 5));
            k_in = DEG_W'(3);
         end
         ST_X2: x2_in = 22'(rnd(acc, 14));
         ST_TS: t_in = 36'(acc <<< 1);
         ST_DS: begin
            if (d_wide > (64'sd1 <<< 39)) begin
               d_in = 41'(64'sd1 <<< 39);
            end else if (d_wide < -(64'sd1 <<< 39)) begin
               d_in = 41'(-(64'sd1 <<< 39));
            end else begin
               d_in = 41'(d_wide);
            end
         end
         ST_TERM: begin
            u_in = u_ff + (40'(x_ff) <<< 13);
            p_in = 31'(rnd(64'(u_in), 10));
            q_in = q_ff + 26'sd65536;
            k_in = k_ff + DEG_W'(1);
         end
         default: begin
            k_in = k_ff;
         end
      endcase

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = (n_ff == '0) ? 32'sd65536 : cell_q[0];
         rsp_sat_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= 16'sd4096;
         degree_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         degree_ff    <= degree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      n_ff         <= n_in;
      k_ff         <= k_in;
      u_ff         <= u_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      x2_ff        <= x2_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   gpe_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .a_op    (a_op),
      .b_chunk (b_chunk),
      .acc     (acc)
   );

   // newest term in cell 0, the one before it in cell 1
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic signed [TERM_W-1:0] cell_d;
      if (i == 0) begin : g_head
         assign cell_d = term_in;
      end else begin : g_link
         assign cell_d = cell_q[i-1];
      end
      gpe_cell u_cell (
         .clock    (clock),
         .shift_en (cell_shift),
         .data_in  (cell_d),
         .data_out (cell_q[i])
      );
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == ST_IDLE)
      else $error("beat accepted while busy");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TERM |-> (k_ff >= DEG_W'(3)) && (k_ff <= n_ff))
      else $error("recurrence index out of range");

   a_degree_zero: assert property (@(posedge clock) disable iff (reset)
      (out_load && n_ff == '0) |=> rsp_valid && rsp_poly_value == 32'sd65536 && !rsp_saturated)
      else $error("degree zero result wrong");

   a_done_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM && k_ff == n_ff) |=> state_ff == ST_DONE)
      else $error("recurrence did not finish");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// gegenbauer polynomial evaluator testbench
// Drives samples under several alpha/degree settings with random gaps and
// output stalls, predicts each C_n^a(x) in fixed point and checks every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class poly_scoreboard;
   logic signed [31:0] exp_value [$];
   logic               exp_sat [$];
   int                 errors;

   function new();
      errors = 0;
   endfunction

   function void note_sample(logic signed [31:0] v, logic s);
      exp_value.push_back(v);
      exp_sat.push_back(s);
   endfunction

   function void check_result(logic signed [31:0] v, logic s);
      logic signed [31:0] ev;
      logic               es;
      if (exp_value.size() == 0) begin
         $display("%0t: unexpected result value %0d sat %0b", $time, v, s);
         errors++;
         return;
      end
      ev = exp_value.pop_front();
      es = exp_sat.pop_front();
      if (v !== ev) begin
         $display("%0t: poly_value expected %0d actual %0d", $time, ev, v);
         errors++;
      end
      if (s !== es) begin
         $display("%0t: saturated expected %0b actual %0b", $time, es, s);
         errors++;
      end
   endfunction

   function int pending();
      return exp_value.size();
   endfunction
endclass

module tb;
   import gpe_pkg::*;

   localparam int MAXDEG = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;
   logic               req_valid;
   logic               req_stall;
   logic signed [17:0] req_sample_x;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_poly_value;
   logic               rsp_saturated;

   logic signed [63:0] cur_alpha;
   int                 cur_degree;
   int                 stall_left;
   bit                 stim_done;
   poly_scoreboard     sb;

   gegenbauer_polynomial_eval #(.MAX_DEGREE(MAXDEG)) DUT (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v, ref logic f);
      if (v > 64'sd2147483647) begin
         f = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         f = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // fixed-point recurrence: x Q14, alpha Q12, terms Q16
   task automatic predict_poly(input logic signed [17:0] xs, output logic signed [31:0] v,
                               output logic f);
      logic signed [63:0] x, a, c1, c2, x2, t, p, q, d, r, lim;
      int n;
      x = xs;
      a = cur_alpha;
      n = cur_degree > MAXDEG ? MAXDEG : cur_degree;
      f = 1'b0;
      lim = 64'sd1 <<< 39;
      if (n == 0) begin
         v = 32'sd65536;
         return;
      end
      c1 = clamp32(round_shift(2 * a * x, 10), f);
      if (n == 1) begin
         v = c1[31:0];
         return;
      end
      x2 = round_shift(x * x, 14);
      t = 2 * a * (64'sd4096 + a);
      c2 = clamp32(round_shift(t * x2 - (a <<< 26), 22), f);
      for (int k = 3; k <= n; k++) begin
         p = round_shift(2 * x * ((k - 1) * 64'sd4096 + a), 10);
         q = ((k - 2) * 64'sd4096 + 2 * a) * 16;
         d = round_shift(p * c2 - q * c1, 16);
         if (d > lim) d = lim;
         if (d < -lim) d = -lim;
         r = ((64'sd1 <<< 24) + (k >> 1)) / k;
         c1 = c2;
         c2 = clamp32(round_shift(d * r, 24), f);
      end
      v = c2[31:0];
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_ALPHA) cur_alpha = $signed(val);
      else if (idx == REG_DEGREE) cur_degree = val[6:0];
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] al, input int dg);
      drain();
      write_reg(REG_ALPHA, al);
      write_reg(REG_DEGREE, 16'(dg));
   endtask

   task automatic send_sample(input logic signed [17:0] xv, input bit gaps);
      int g;
      g = 1;
      if (gaps && $urandom_range(0, 2) == 0) begin
         g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(2, 4);
      end
      repeat (g) @(negedge clock);
      req_valid    <= 1'b1;
      req_sample_x <= xv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [17:0] rand_x();
      case ($urandom_range(0, 4))
         0: return 18'($urandom_range(0, 32768)) - 18'sd16384;
         1: return ($urandom_range(0, 1)) ? 18'sd131071 : -18'sd131072;
         default: return 18'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] rand_alpha();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 8192));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic int rand_degree();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(65, 127);
      if (r == 1) return 64;
      if (r < 6) return $urandom_range(0, 2);
      return $urandom_range(3, 12);
   endfunction

   // accepted input beats feed the scoreboard
   always @(posedge clock) begin
      logic signed [31:0] v;
      logic f;
      if (!reset && req_valid && !req_stall) begin
         predict_poly(req_sample_x, v, f);
         sb.note_sample(v, f);
      end
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_poly_value, rsp_saturated);
   end

   // result-side stall: mostly short bursts, now and then a long one
   always @(negedge clock) begin
      if (reset || stim_done) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      logic signed [17:0] dir_x [8];
      sb = new();
      stim_done = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_sample_x = '0;
      cur_alpha = 64'sd4096;
      cur_degree = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_x = '{18'sd0, 18'sd16384, -18'sd16384, 18'sd131071, -18'sd131072,
                18'sd8192, -18'sd1, 18'sd1};
      // reset settings: degree zero
      send_sample(18'sd131071, 0);
      send_sample(-18'sd131072, 0);
      drain();
      write_reg(REG_UNUSED, 16'hFFFF);
      foreach (dir_x[i]) begin
         set_config(16'(4096 + i * 1000), i < 3 ? i : i * 8);
         send_sample(dir_x[i], 0);
         send_sample(-dir_x[i], 0);
      end
      set_config(16'h7FFF, 64);
      send_sample(18'sd131071, 0);
      send_sample(18'sd100, 0);
      set_config(16'h8000, 127);
      send_sample(-18'sd131072, 0);
      send_sample(18'sd16384, 0);
      set_config(16'h0000, 5);
      send_sample(18'sd12345, 0);

      for (int ph = 0; ph < 40; ph++) begin
         set_config(rand_alpha(), rand_degree());
         for (int i = 0; i < 13; i++) send_sample(rand_x(), ph % 4 != 0);
         // hold off until everything is back
         if (ph % 10 == 5) while (sb.pending() != 0) @(negedge clock);
      end

      stim_done = 1;
      while (sb.pending() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule

[sim.f]
rtl/gpe_pkg.sv
rtl/gpe_cell.sv
rtl/gpe_mac.sv
rtl/gegenbauer_polynomial_eval.sv
dv/tb.sv
